// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DTSL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtsl assertion failed");

// next-cycle implication
`define DTSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtsl assertion failed");

`else

`define DTSL_ASSERT_SAME(label, clk, rst, ante, cons)
`define DTSL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/dtsl_pkg.sv -----
`default_nettype none

package dtsl_pkg;

   localparam int VAL_W = 16;
   localparam int SUM_W = 21;

   // transaction commands
   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_READ_HOUR = 2'd1,
      CMD_READ_DAY  = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [15:0] temperature_now;
      logic [4:0]         clock_hour;
      logic [5:0]         clock_minute;
      logic [7:0]         entry_index;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [15:0] first_value;
      logic signed [15:0] second_value;
      logic signed [15:0] third_value;
      logic [2:0]         day_slot_now;
      logic [4:0]         hour_slot_now;
   } rsp_type;

   // one day record
   typedef struct packed {
      logic signed [VAL_W-1:0] hi_val;
      logic signed [VAL_W-1:0] lo_val;
      logic signed [VAL_W-1:0] avg_val;
   } day_rec_type;

endpackage

`default_nettype wire

// ----- rtl/core/dtsl_stream_if.sv -----
`default_nettype none

// valid/ready channel carrying one payload per transaction
interface dtsl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dtsl_avg_div.sv -----
`default_nettype none

// signed running sum divided by HOURS, truncated toward zero, saturated to 16 bits
module dtsl_avg_div #(
   parameter int HOURS = 24
) (
   input  wire logic signed [dtsl_pkg::SUM_W-1:0] sum,
   output logic signed [dtsl_pkg::VAL_W-1:0]      avg
);

   localparam int SW      = dtsl_pkg::SUM_W;
   localparam int RECIP_K = SW + $clog2(HOURS);
   localparam logic [RECIP_K:0] RECIP_M =
      (RECIP_K+1)'(((64'd1 << RECIP_K) + 64'(HOURS) - 64'd1) / 64'(HOURS));
   localparam logic [SW-1:0] POS_LIMIT = SW'(32767);
   localparam logic [SW-1:0] NEG_LIMIT = SW'(32768);

   logic [SW-1:0]         mag;
   logic [SW+RECIP_K:0]   prod;
   logic [SW-1:0]         q_mag;
   logic [SW-1:0]         q_neg;

   // magnitude, then reciprocal multiply (exact for every 21-bit magnitude)
   assign mag   = sum[SW-1] ? SW'(-sum) : SW'(sum);
   assign prod  = mag * RECIP_M;
   assign q_mag = prod[RECIP_K +: SW];
   assign q_neg = SW'(-q_mag);

   // restore sign and clamp
   always_comb begin
      if (!sum[SW-1]) begin
         avg = (q_mag > POS_LIMIT) ? 16'sh7fff : q_mag[15:0];
      end else begin
         avg = (q_mag > NEG_LIMIT) ? 16'sh8000 : q_neg[15:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dtsl_hour_log.sv -----
`default_nettype none

// hourly sample table with its write pointer
module dtsl_hour_log #(
   parameter int HOURS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            log_en,
   input  wire logic signed [dtsl_pkg::VAL_W-1:0] sample,
   input  wire logic [7:0]                      rd_index,
   output logic                                 rd_ok,
   output logic signed [dtsl_pkg::VAL_W-1:0]    rd_data,
   output logic [4:0]                           slot_after
);

   localparam int HSW = (HOURS > 1) ? $clog2(HOURS) : 1;

   logic [HSW-1:0]                    slot_ff;
   logic [HSW-1:0]                    slot_in;
   logic [HSW-1:0]                    slot_next;
   logic [7:0]                        slot_wide;
   logic signed [dtsl_pkg::VAL_W-1:0] samples_ff [HOURS];

   // pointer advance with wrap at HOURS
   assign slot_next  = (slot_ff == HSW'(HOURS - 1)) ? '0 : slot_ff + 1'b1;
   assign slot_in    = log_en ? slot_next : slot_ff;
   assign slot_wide  = 8'(slot_in);
   assign slot_after = slot_wide[4:0];

   // read side
   assign rd_ok   = rd_index < 8'(HOURS);
   assign rd_data = rd_ok ? samples_ff[rd_index[HSW-1:0]] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         for (int i = 0; i < HOURS; i++) begin
            samples_ff[i] <= '0;
         end
      end else if (log_en) begin
         samples_ff[slot_ff] <= sample;
         slot_ff             <= slot_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dtsl_core.sv -----
`default_nettype none

// day state, day records and result assembly for one transaction per cycle; ticks update state only when fire is high
module dtsl_core #(
   parameter int DAYS  = 7,
   parameter int HOURS = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire dtsl_pkg::req_type item,
   output dtsl_pkg::rsp_type      result
);

   localparam int DSW = (DAYS > 1) ? $clog2(DAYS) : 1;
   localparam int SW  = dtsl_pkg::SUM_W;

   logic                              active_ff, active_in;
   logic [4:0]                        last_hour_ff, last_hour_in;
   logic signed [SW-1:0]              sum_ff, sum_in;
   logic [DSW-1:0]                    day_slot_ff, day_slot_in, day_next, rd_slot;
   dtsl_pkg::day_rec_type             rec_ff [DAYS];
   dtsl_pkg::day_rec_type             cur, wr_rec;
   logic                              is_tick, at_midnight, new_hour;
   logic                              day_open, hour_update, day_close;
   logic                              wr_hilo, wr_avg, avg_here;
   logic                              day_idx_ok;
   logic signed [dtsl_pkg::VAL_W-1:0] t_now, avg_q, hour_data;
   logic                              hour_ok;
   logic [4:0]                        hour_slot_after;
   logic [7:0]                        day_slot_wide;

   assign t_now = item.temperature_now;

   // tick decode
   assign is_tick     = fire && (item.command == dtsl_pkg::CMD_TICK);
   assign at_midnight = (item.clock_hour == '0) && (item.clock_minute == '0);
   assign new_hour    = active_ff && (item.clock_minute == '0)
                        && (last_hour_ff != item.clock_hour);
   assign day_open    = is_tick && !active_ff && at_midnight;
   assign hour_update = is_tick && new_hour && (item.clock_hour != '0);
   assign day_close   = is_tick && new_hour && (item.clock_hour == '0);

   // day ring pointer
   assign day_next    = (day_slot_ff == DSW'(DAYS - 1)) ? '0 : day_slot_ff + 1'b1;
   assign day_slot_in = day_close ? day_next : day_slot_ff;

   // one read of the day records: slot after the tick, or the requested slot
   assign day_idx_ok = item.entry_index < 8'(DAYS);
   assign rd_slot    = (item.command == dtsl_pkg::CMD_TICK) ? day_slot_in
                                                            : item.entry_index[DSW-1:0];
   assign cur        = rec_ff[rd_slot];

   dtsl_avg_div #(
      .HOURS (HOURS)
   ) u_avg_div (
      .sum (sum_ff),
      .avg (avg_q)
   );

   // new record values for the current slot
   always_comb begin
      wr_rec.hi_val  = day_open ? t_now : ((cur.hi_val < t_now) ? t_now : cur.hi_val);
      wr_rec.lo_val  = day_open ? t_now : ((cur.lo_val > t_now) ? t_now : cur.lo_val);
      wr_rec.avg_val = day_open ? t_now : avg_q;
   end
   assign wr_hilo  = day_open || hour_update;
   assign wr_avg   = day_open || day_close;
   assign avg_here = wr_avg && (rd_slot == day_slot_ff);

   // running day state
   always_comb begin
      active_in    = active_ff;
      last_hour_in = last_hour_ff;
      sum_in       = sum_ff;
      if (day_open) begin
         active_in    = 1'b1;
         last_hour_in = '0;
         sum_in       = SW'(t_now);
      end else if (hour_update) begin
         last_hour_in = item.clock_hour;
         sum_in       = sum_ff + SW'(t_now);
      end else if (day_close) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         last_hour_ff <= '0;
         sum_ff       <= '0;
         day_slot_ff  <= '0;
         for (int i = 0; i < DAYS; i++) begin
            rec_ff[i] <= '0;
         end
      end else begin
         active_ff    <= active_in;
         last_hour_ff <= last_hour_in;
         sum_ff       <= sum_in;
         day_slot_ff  <= day_slot_in;
         if (wr_hilo) begin
            rec_ff[day_slot_ff].hi_val <= wr_rec.hi_val;
            rec_ff[day_slot_ff].lo_val <= wr_rec.lo_val;
         end
         if (wr_avg) begin
            rec_ff[day_slot_ff].avg_val <= wr_rec.avg_val;
         end
      end
   end

   dtsl_hour_log #(
      .HOURS (HOURS)
   ) u_hour_log (
      .clock      (clock),
      .reset      (reset),
      .log_en     (day_open || hour_update),
      .sample     (t_now),
      .rd_index   (item.entry_index),
      .rd_ok      (hour_ok),
      .rd_data    (hour_data),
      .slot_after (hour_slot_after)
   );

   assign day_slot_wide = 8'(day_slot_in);

   // result transaction
   always_comb begin
      result               = '0;
      result.day_slot_now  = day_slot_wide[2:0];
      result.hour_slot_now = hour_slot_after;
      unique case (item.command)
         dtsl_pkg::CMD_TICK: begin
            result.ok           = 1'b1;
            result.first_value  = wr_hilo ? wr_rec.hi_val : cur.hi_val;
            result.second_value = wr_hilo ? wr_rec.lo_val : cur.lo_val;
            result.third_value  = avg_here ? wr_rec.avg_val : cur.avg_val;
         end
         dtsl_pkg::CMD_READ_HOUR: begin
            result.ok          = hour_ok;
            result.first_value = hour_data;
         end
         dtsl_pkg::CMD_READ_DAY: begin
            result.ok = day_idx_ok;
            if (day_idx_ok) begin
               result.first_value  = cur.hi_val;
               result.second_value = cur.lo_val;
               result.third_value  = cur.avg_val;
            end
         end
         default: begin
            result.ok = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/daily_temperature_stats_logger_top.sv -----
// Daily temperature statistics logger. Ticks (command 0) carry temperature and
// real-time-clock hour and minute; the block opens a day record at 00:00, logs an
// hourly sample and tracks max/min on each new hour at minute 0, and at the next
// midnight stores the average (sum / HOURS, truncated toward zero, saturated) and
// moves to the next slot of a DAYS-deep day ring. Commands 1 and 2 read an hourly
// sample or a day record with an in-range flag. One transaction is taken every
// cycle unless the input is stalled; its result passes through the input
// register, which holds it while the update runs, and then the result register,
// which presents it. A result that waits on the output stalls the input only once
// both registers are full. The tick update, with its reciprocal multiply for the
// average, sits between those two registers. Both tables are cleared directly by
// reset, so the block is ready the cycle after.
`default_nettype none
`include "assert_macros.svh"

module daily_temperature_stats_logger_top #(
   parameter int DAYS  = 7,
   parameter int HOURS = 24
) (
   input wire logic      clock,
   input wire logic      reset,
   dtsl_stream_if.sink   req_chan,
   dtsl_stream_if.source rsp_chan
);

   logic              s1_valid_ff, s1_valid_in;
   dtsl_pkg::req_type s1_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   dtsl_pkg::rsp_type rsp_data_ff;
   dtsl_pkg::rsp_type core_result;
   logic              out_adv, s1_fire, req_accept;
   logic              tick_fire, rsp_rejected, rsp_all_zero;

   // pipeline advance
   assign out_adv    = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire    = s1_valid_ff && out_adv;
   assign req_chan.ready = !s1_valid_ff || out_adv;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_chan.ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_chan.payload;
      end
   end

   dtsl_core #(
      .DAYS  (DAYS),
      .HOURS (HOURS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item_ff),
      .result (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // terms for the checks
   assign tick_fire    = s1_fire && (s1_item_ff.command == dtsl_pkg::CMD_TICK);
   assign rsp_rejected = rsp_valid_ff && !rsp_data_ff.ok;
   assign rsp_all_zero = (rsp_data_ff.first_value == '0)
                         && (rsp_data_ff.second_value == '0)
                         && (rsp_data_ff.third_value == '0);

   // checks
   `DTSL_ASSERT_NEXT(a_fire_fills_output, clock, reset, s1_fire, rsp_valid_ff)
   `DTSL_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_accept, s1_valid_ff)
   `DTSL_ASSERT_NEXT(a_tick_ok, clock, reset, tick_fire, rsp_data_ff.ok)
   `DTSL_ASSERT_SAME(a_reject_zero, clock, reset, rsp_rejected, rsp_all_zero)

endmodule

`default_nettype wire
